### hdl/wbdm_pkg.sv
// Shared constants, types and helpers of the word-wise byte difference marker.
package wbdm_pkg;

    localparam int LINE_WIDTH     = 16;
    localparam int MAX_WORD_BYTES = 8;
    localparam int BYTE_W         = 8;
    localparam int WORD_W         = BYTE_W * MAX_WORD_BYTES;
    localparam int TOTAL_W        = 16;
    localparam int WSIZE_W        = 4;
    localparam int ENTRY_IDX_W    = 4;

    localparam int LINE_AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
    localparam int OFF_W   = $clog2(LINE_WIDTH + 1);
    localparam int POS_W   = $clog2(LINE_WIDTH + 2 * MAX_WORD_BYTES);
    localparam int CNT_W   = $clog2(MAX_WORD_BYTES + 1);

    localparam logic [OFF_W-1:0]   LINE_END  = OFF_W'(LINE_WIDTH);
    localparam logic [POS_W-1:0]   LINE_POS  = POS_W'(LINE_WIDTH);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration register indexes
    localparam logic CFG_WSIZE  = 1'b0;
    localparam logic CFG_ABSENT = 1'b1;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_CMP    = 2'd1,
        KIND_IGNORE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RES_CMP = 2'd0,
        RES_IGN = 2'd1,
        RES_RD  = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic [BYTE_W-1:0] mark;
        logic [BYTE_W-1:0] diff;
        logic [BYTE_W-1:0] absent;
    } entry_t;

    typedef struct packed {
        logic     clear;
        logic     cmp_step;
        logic     rd_entry;
        logic     ign_start;
        logic     abs_wr;
        logic     fin_calc;
        logic     fin_rd;
        logic     fin_wr;
        logic     ign_rd;
        logic     ign_shift;
        logic     ign_next;
        logic     ign_clr_rd;
        logic     ign_clr_wr;
        logic     emit;
        res_sel_t sel;
    } cmd_t;

    typedef struct packed {
        logic abs_pend;
        logic done_pend;
        logic word_flag;
        logic fin_more;
        logic ign_j_last;
        logic ign_match;
        logic ign_more;
        logic ign_last_word;
        logic out_free;
    } status_t;

    // Clamp the programmed word size to 1..MAX_WORD_BYTES
    function automatic logic [CNT_W-1:0] eff_wsize(input logic [WSIZE_W-1:0] raw);
        logic [CNT_W-1:0] ws;
        if (raw == '0)
            ws = CNT_W'(1);
        else if (32'(raw) > MAX_WORD_BYTES)
            ws = CNT_W'(MAX_WORD_BYTES);
        else
            ws = CNT_W'(raw);
        return ws;
    endfunction

endpackage

### hdl/wbdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wbdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/wbdm_ctrl.sv
// Sequencer of the difference marker: steps each item through the datapath.
module wbdm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic [1:0]       kind,
    output logic             item_stall,
    output wbdm_pkg::cmd_t    cmd,
    input  wbdm_pkg::status_t status
);

    import wbdm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP_ABS,
        S_FIN_CALC,
        S_FIN_RD,
        S_FIN_WR,
        S_IGN_RD,
        S_IGN_SH,
        S_IGN_CMP,
        S_IGN_CLR_RD,
        S_IGN_CLR_WR,
        S_EMIT
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t sel_reg, sel_next;
    kind_t    kind_in;

    assign kind_in    = kind_t'(kind);
    assign item_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = sel_reg;
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (kind_in)
                        KIND_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        KIND_CMP:
                        begin
                            cmd.cmp_step = 1'b1;
                            state_next   = S_CMP_ABS;
                        end
                        KIND_IGNORE:
                        begin
                            cmd.ign_start = 1'b1;
                            sel_next      = RES_IGN;
                            state_next    = S_IGN_RD;
                        end
                        KIND_READ:
                        begin
                            cmd.rd_entry = 1'b1;
                            sel_next     = RES_RD;
                            state_next   = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CMP_ABS:
            begin
                cmd.abs_wr = status.abs_pend;
                state_next = status.done_pend ? S_FIN_CALC : S_IDLE;
            end
            S_FIN_CALC:
            begin
                cmd.fin_calc = 1'b1;
                sel_next     = RES_CMP;
                state_next   = status.word_flag ? S_FIN_RD : S_EMIT;
            end
            S_FIN_RD:
            begin
                if (status.fin_more)
                begin
                    cmd.fin_rd = 1'b1;
                    state_next = S_FIN_WR;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_FIN_WR:
            begin
                cmd.fin_wr = 1'b1;
                state_next = S_FIN_RD;
            end
            S_IGN_RD:
            begin
                cmd.ign_rd = 1'b1;
                state_next = S_IGN_SH;
            end
            S_IGN_SH:
            begin
                cmd.ign_shift = 1'b1;
                state_next    = status.ign_j_last ? S_IGN_CMP : S_IGN_RD;
            end
            S_IGN_CMP:
            begin
                if (status.ign_match)
                begin
                    state_next = S_IGN_CLR_RD;
                end
                else
                begin
                    cmd.ign_next = 1'b1;
                    state_next   = status.ign_last_word ? S_EMIT : S_IGN_RD;
                end
            end
            S_IGN_CLR_RD:
            begin
                if (status.ign_more)
                begin
                    cmd.ign_clr_rd = 1'b1;
                    state_next     = S_IGN_CLR_WR;
                end
                else
                begin
                    cmd.ign_next = 1'b1;
                    state_next   = status.ign_last_word ? S_EMIT : S_IGN_RD;
                end
            end
            S_IGN_CLR_WR:
            begin
                cmd.ign_clr_wr = 1'b1;
                state_next     = S_IGN_CLR_RD;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= RES_CMP;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cmp_goes_abs: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && kind_in == KIND_CMP) |=> state_reg == S_CMP_ABS)
        else $error("compare item did not enter the absent-count step");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !status.out_free) |=> state_reg == S_EMIT)
        else $error("result dropped while output register was busy");

    a_clr_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IGN_CLR_WR) |=> state_reg == S_IGN_CLR_RD)
        else $error("unmark write did not return to the unmark read");
`endif

endmodule

### hdl/wbdm_dp.sv
// Datapath of the difference marker: word accumulators, line entry RAM, totals, result register.
module wbdm_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  wbdm_pkg::cmd_t                           cmd,
    output wbdm_pkg::status_t                        status,
    input  logic [wbdm_pkg::CNT_W-1:0]               ws,
    input  logic                                     absent_is_different,
    input  logic                                     cfg_drop,
    input  logic [7:0]                               ref_byte,
    input  logic                                     ref_present,
    input  logic [7:0]                               cmp_byte,
    input  logic                                     cmp_present,
    input  logic                                     range_end,
    input  logic [63:0]                              ignore_value,
    input  logic [wbdm_pkg::ENTRY_IDX_W-1:0]         entry_index,
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output logic                                     word_different,
    output logic [63:0]                              difference_word,
    output logic [wbdm_pkg::TOTAL_W-1:0]             total_count,
    output logic [7:0]                               mark_count,
    output logic [7:0]                               diff_byte,
    output logic [7:0]                               absent_count
);

    import wbdm_pkg::*;

    // Control state
    logic [WORD_W-1:0]     ref_acc_reg, cmp_acc_reg;
    logic                  flag_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [OFF_W-1:0]      offset_reg, start_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [LINE_WIDTH-1:0] valid_reg;
    logic                  abs_pend_reg, done_pend_reg, end_pend_reg;
    logic [POS_W-1:0]      i_reg;
    logic [CNT_W-1:0]      j_reg, k_reg;
    logic                  rd_live_reg;
    logic                  result_valid_reg;

    // Payload
    logic [LINE_AW-1:0]    abs_addr_reg;
    logic [WORD_W-1:0]     diff_word_reg, ignore_reg, s_word_reg;
    logic                  res_wd_reg;
    logic [WORD_W-1:0]     res_dw_reg;
    logic [TOTAL_W-1:0]    res_total_reg;
    entry_t                res_entry_reg;

    // Compare step
    logic [WORD_W-1:0]     ref_n, cmp_n;
    logic                  flag_n, absent_n;
    logic [CNT_W-1:0]      fill_inc;

    // RAM ports
    logic                  rd_en, rd_gate, wr_en;
    logic [LINE_AW-1:0]    rd_addr, wr_addr;
    entry_t                rd_data, wr_data, cur;

    logic [POS_W-1:0]      fin_pos, ign_pos;
    logic [CNT_W-1:0]      pad, sh;
    logic [BYTE_W-1:0]     byte_sel;
    logic [TOTAL_W:0]      total_sum;
    logic [TOTAL_W-1:0]    total_add, total_sub, mark_ext;

    always_comb
    begin
        ref_n    = ref_acc_reg << BYTE_W;
        cmp_n    = cmp_acc_reg << BYTE_W;
        flag_n   = flag_reg;
        absent_n = 1'b0;
        priority if (ref_present && cmp_present)
        begin
            ref_n  = ref_n | WORD_W'(ref_byte);
            cmp_n  = cmp_n | WORD_W'(cmp_byte);
            flag_n = flag_reg | (ref_n != cmp_n);
        end
        else if (!ref_present && !cmp_present)
        begin
            absent_n = 1'b1;
        end
        else if (absent_is_different)
        begin
            if (ref_present)
                ref_n = ref_n | WORD_W'(ref_byte);
            else
                cmp_n = cmp_n | WORD_W'(cmp_byte);
            flag_n = 1'b1;
        end
        else
        begin
            absent_n = 1'b1;
        end
    end

    assign fill_inc = fill_reg + CNT_W'(1);
    assign fin_pos  = POS_W'(start_reg) + POS_W'(k_reg);
    assign ign_pos  = i_reg + POS_W'(j_reg);
    assign cur      = rd_live_reg ? rd_data : '0;

    assign pad      = ws - fill_reg;
    assign sh       = ws - CNT_W'(1) - k_reg;
    assign byte_sel = BYTE_W'(diff_word_reg >> {sh, 3'b000});

    assign total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(ws);
    assign total_add = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    assign mark_ext  = TOTAL_W'(cur.mark);
    assign total_sub = (total_reg > mark_ext) ? (total_reg - mark_ext) : '0;

    // Read port: one address per command
    always_comb
    begin
        rd_en   = cmd.cmp_step | cmd.rd_entry | cmd.fin_rd | cmd.ign_rd | cmd.ign_clr_rd;
        rd_gate = 1'b1;
        priority if (cmd.cmp_step)
        begin
            rd_addr = offset_reg[LINE_AW-1:0];
        end
        else if (cmd.rd_entry)
        begin
            rd_addr = LINE_AW'(entry_index);
            rd_gate = (32'(entry_index) < LINE_WIDTH);
        end
        else if (cmd.fin_rd)
        begin
            rd_addr = fin_pos[LINE_AW-1:0];
        end
        else
        begin
            rd_addr = ign_pos[LINE_AW-1:0];
            rd_gate = (ign_pos < LINE_POS);
        end
    end

    // Write port: read-modify-write of one entry
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = abs_addr_reg;
        wr_data = cur;
        priority if (cmd.abs_wr)
        begin
            wr_en          = 1'b1;
            wr_data.absent = cur.absent + BYTE_W'(1);
        end
        else if (cmd.fin_wr)
        begin
            wr_en        = 1'b1;
            wr_addr      = fin_pos[LINE_AW-1:0];
            wr_data.mark = cur.mark + BYTE_W'(1);
            if (cur.mark == '0)
                wr_data.diff = byte_sel;
        end
        else if (cmd.ign_clr_wr)
        begin
            wr_en   = (cur.mark != '0);
            wr_addr = ign_pos[LINE_AW-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    wbdm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (LINE_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_acc_reg      <= '0;
            cmp_acc_reg      <= '0;
            flag_reg         <= 1'b0;
            fill_reg         <= '0;
            offset_reg       <= '0;
            start_reg        <= '0;
            total_reg        <= '0;
            valid_reg        <= '0;
            abs_pend_reg     <= 1'b0;
            done_pend_reg    <= 1'b0;
            end_pend_reg     <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            rd_live_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                ref_acc_reg <= '0;
                cmp_acc_reg <= '0;
                flag_reg    <= 1'b0;
                fill_reg    <= '0;
                offset_reg  <= '0;
                start_reg   <= '0;
                total_reg   <= '0;
                valid_reg   <= '0;
            end
            if (cfg_drop)
            begin
                ref_acc_reg <= '0;
                cmp_acc_reg <= '0;
                flag_reg    <= 1'b0;
                fill_reg    <= '0;
            end
            if (cmd.cmp_step)
            begin
                ref_acc_reg   <= ref_n;
                cmp_acc_reg   <= cmp_n;
                flag_reg      <= flag_n;
                fill_reg      <= fill_inc;
                if (fill_reg == '0)
                    start_reg <= offset_reg;
                if (offset_reg < LINE_END)
                    offset_reg <= offset_reg + OFF_W'(1);
                abs_pend_reg  <= absent_n && (offset_reg < LINE_END);
                done_pend_reg <= (fill_inc >= ws) || range_end;
                end_pend_reg  <= range_end;
            end
            if (rd_en)
            begin
                rd_live_reg <= valid_reg[rd_addr] && rd_gate;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.fin_calc)
            begin
                k_reg <= '0;
                if (flag_reg)
                    total_reg <= total_add;
            end
            if (cmd.fin_wr)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            if (cmd.ign_start)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            if (cmd.ign_shift)
            begin
                j_reg <= status.ign_j_last ? '0 : (j_reg + CNT_W'(1));
            end
            if (cmd.ign_next)
            begin
                i_reg <= i_reg + POS_W'(ws);
                j_reg <= '0;
            end
            if (cmd.ign_clr_wr)
            begin
                j_reg <= j_reg + CNT_W'(1);
                if (cur.mark != '0)
                    total_reg <= total_sub;
            end
            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
                if (cmd.sel == RES_CMP)
                begin
                    ref_acc_reg <= '0;
                    cmp_acc_reg <= '0;
                    flag_reg    <= 1'b0;
                    fill_reg    <= '0;
                    if (end_pend_reg)
                    begin
                        offset_reg <= '0;
                        start_reg  <= '0;
                    end
                end
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp_step)
        begin
            abs_addr_reg <= offset_reg[LINE_AW-1:0];
        end
        if (cmd.fin_calc)
        begin
            diff_word_reg <= (cmp_acc_reg << {pad, 3'b000}) - (ref_acc_reg << {pad, 3'b000});
        end
        if (cmd.ign_start)
        begin
            ignore_reg <= ignore_value;
            s_word_reg <= '0;
        end
        if (cmd.ign_shift)
        begin
            s_word_reg <= {s_word_reg[WORD_W-BYTE_W-1:0], cur.diff};
        end
        if (cmd.ign_next)
        begin
            s_word_reg <= '0;
        end
        if (cmd.emit)
        begin
            res_total_reg <= total_reg;
            unique case (cmd.sel)
                RES_CMP:
                begin
                    res_wd_reg    <= flag_reg;
                    res_dw_reg    <= diff_word_reg;
                    res_entry_reg <= '0;
                end
                RES_RD:
                begin
                    res_wd_reg    <= 1'b0;
                    res_dw_reg    <= '0;
                    res_entry_reg <= cur;
                end
                default:
                begin
                    res_wd_reg    <= 1'b0;
                    res_dw_reg    <= '0;
                    res_entry_reg <= '0;
                end
            endcase
        end
    end

    always_comb
    begin
        status.abs_pend      = abs_pend_reg;
        status.done_pend     = done_pend_reg;
        status.word_flag     = flag_reg;
        status.fin_more      = (k_reg < fill_reg) && (fin_pos < LINE_POS);
        status.ign_j_last    = (j_reg == (ws - CNT_W'(1)));
        status.ign_match     = (s_word_reg == ignore_reg);
        status.ign_more      = (j_reg < ws) && (ign_pos < LINE_POS);
        status.ign_last_word = ((i_reg + POS_W'(ws)) >= LINE_POS);
        status.out_free      = !result_valid_reg || !result_stall;
    end

    assign result_valid    = result_valid_reg;
    assign word_different  = res_wd_reg;
    assign difference_word = res_dw_reg;
    assign total_count     = res_total_reg;
    assign mark_count      = res_entry_reg.mark;
    assign diff_byte       = res_entry_reg.diff;
    assign absent_count    = res_entry_reg.absent;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ws)
        else $error("pending word holds more bytes than the word size");

    a_total_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_calc |=> total_reg >= $past(total_reg))
        else $error("total fell while closing a word");

    a_total_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ign_clr_wr |=> total_reg <= $past(total_reg))
        else $error("total grew while unmarking");
`endif

endmodule

### hdl/wordwise_byte_diff_marker.sv
// Top level of the word-wise byte difference marker: configuration registers and unit wiring.
//
// Compares a reference line against a comparison line one byte pair per compare item,
// grouping bytes into big-endian words of the programmed word size (0 acts as 1, above
// 8 acts as 8). Items are taken one at a time; the per-byte line state lives in a
// 16-entry RAM with one read and one write port (mark count, difference byte, absent
// count per byte), each entry written in the cycle after it is read. A clear item
// gives no result; a read item reads one entry and gives a result. A compare byte
// counts an absent byte in its entry; one that does not close a word gives no result,
// and one that closes a word pads it, adds to the total when it differs, then reads
// and marks each byte of the word inside the line when it differs, and gives a result.
// An ignore item walks the line word by word, reading each word's stored difference
// bytes; for a word whose difference equals ignore_value it reads and unmarks each
// byte inside the line, and at the end it gives a result. Valid bits cleared at reset
// and by a clear item stand in for clearing the RAM, so there is no clearing pass. The
// result sits in an output register, so the next item is accepted while a finished
// result still waits; a result produced while the previous one is still stalled holds
// the sequencer until the output register frees. A write to the word size register
// drops any partly built word; configuration must be written only while the block is
// idle, which the block itself does not enforce.
module wordwise_byte_diff_marker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [wbdm_pkg::WSIZE_W-1:0]       cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [1:0]                         kind,
    input  logic [7:0]                         ref_byte,
    input  logic                               ref_present,
    input  logic [7:0]                         cmp_byte,
    input  logic                               cmp_present,
    input  logic                               range_end,
    input  logic [63:0]                        ignore_value,
    input  logic [wbdm_pkg::ENTRY_IDX_W-1:0]   entry_index,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic                               word_different,
    output logic [63:0]                        difference_word,
    output logic [wbdm_pkg::TOTAL_W-1:0]       total_count,
    output logic [7:0]                         mark_count,
    output logic [7:0]                         diff_byte,
    output logic [7:0]                         absent_count
);

    import wbdm_pkg::*;

    logic [WSIZE_W-1:0] wsize_reg;
    logic               absent_is_different_reg;
    logic [CNT_W-1:0]   ws;
    logic               cfg_drop;
    cmd_t               cmd;
    status_t            status;

    // Word size takes effect clamped; writing it also drops the pending word
    assign ws       = eff_wsize(wsize_reg);
    assign cfg_drop = cfg_write && (cfg_index == CFG_WSIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg               <= WSIZE_W'(1);
            absent_is_different_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WSIZE:  wsize_reg               <= cfg_data;
                CFG_ABSENT: absent_is_different_reg <= cfg_data[0];
                default:    wsize_reg               <= wsize_reg;
            endcase
        end
    end

    // Sequencer: accept an item, then step it through the RAM read and write cycles
    wbdm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .kind       (kind),
        .item_stall (item_stall),
        .cmd        (cmd),
        .status     (status)
    );

    // Datapath: accumulators, line RAM, total and the result register
    wbdm_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .ws                  (ws),
        .absent_is_different (absent_is_different_reg),
        .cfg_drop            (cfg_drop),
        .ref_byte            (ref_byte),
        .ref_present         (ref_present),
        .cmp_byte            (cmp_byte),
        .cmp_present         (cmp_present),
        .range_end           (range_end),
        .ignore_value        (ignore_value),
        .entry_index         (entry_index),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .word_different      (word_different),
        .difference_word     (difference_word),
        .total_count         (total_count),
        .mark_count          (mark_count),
        .diff_byte           (diff_byte),
        .absent_count        (absent_count)
    );

endmodule

### tb/tb.sv
// Self-checking testbench of the word-wise byte difference marker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wbdm_pkg::*;

    // Cycles with no item accepted on either side before the run is called hung.
    // Worst legitimate quiet stretch: a long sender gap, a long result stall and a
    // full ignore walk of the line, or the settle pause before a register write.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles to let pass after the last expected result before touching the
    // registers or ending: covers items that give no result (clear, open word).
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_ITEMS   = 200;
    localparam int SOAK_ITEMS     = 280;
    localparam int MAX_PRINTS     = 30;

    // One input item as driven onto the ports
    typedef struct {
        kind_t       kind;
        logic [7:0]  ref_b;
        logic        ref_p;
        logic [7:0]  cmp_b;
        logic        cmp_p;
        logic        last;
        logic [63:0] ign;
        logic [3:0]  idx;
    } item_t;

    // One result item as seen on the ports
    typedef struct {
        logic        wd;
        logic [63:0] dw;
        logic [15:0] tot;
        logic [7:0]  mark;
        logic [7:0]  dbyte;
        logic [7:0]  absent;
    } outcome_t;

    // Row of the directed plan: either a register write or an item, with an
    // optional hand-typed result
    typedef struct {
        bit         is_cfg;
        logic       cfg_sel;
        logic [3:0] cfg_val;
        item_t      it;
        bit         typed;
        outcome_t   want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [3:0]  cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  kind;
    logic [7:0]  ref_byte;
    logic        ref_present;
    logic [7:0]  cmp_byte;
    logic        cmp_present;
    logic        range_end;
    logic [63:0] ignore_value;
    logic [3:0]  entry_index;
    logic        result_valid;
    logic        result_stall;
    logic        word_different;
    logic [63:0] difference_word;
    logic [15:0] total_count;
    logic [7:0]  mark_count;
    logic [7:0]  diff_byte;
    logic [7:0]  absent_count;

    wordwise_byte_diff_marker dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .kind            (kind),
        .ref_byte        (ref_byte),
        .ref_present     (ref_present),
        .cmp_byte        (cmp_byte),
        .cmp_present     (cmp_present),
        .range_end       (range_end),
        .ignore_value    (ignore_value),
        .entry_index     (entry_index),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .word_different  (word_different),
        .difference_word (difference_word),
        .total_count     (total_count),
        .mark_count      (mark_count),
        .diff_byte       (diff_byte),
        .absent_count    (absent_count)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the marker: registers, pending word and line tables
    // ------------------------------------------------------------------
    logic [3:0]  sh_ws_raw;
    logic        sh_absent_diff;
    logic [63:0] sh_ref_word;
    logic [63:0] sh_cmp_word;
    bit          sh_word_differs;
    int unsigned sh_offset;
    int unsigned sh_fill;
    int unsigned sh_start;
    logic [7:0]  sh_marks   [16];
    logic [7:0]  sh_dbytes  [16];
    logic [7:0]  sh_absents [16];
    int unsigned sh_total;

    outcome_t    pending_results[$];

    int          mismatches;
    int          items_sent;
    int          soak_sent;
    int          results_seen;
    int          reg_writes;
    int          quiet_cycles;
    bit          src_steady;
    bit          sink_steady;

    // Clamp the programmed word size the way the block reads it
    function automatic int unsigned word_bytes();
        int unsigned w;
        w = 32'(sh_ws_raw);
        if (w < 1) w = 1;
        if (w > 8) w = 8;
        return w;
    endfunction

    function automatic void drop_word();
        sh_ref_word     = '0;
        sh_cmp_word     = '0;
        sh_word_differs = 0;
        sh_fill         = 0;
    endfunction

    function automatic void clear_line();
        drop_word();
        sh_offset = 0;
        sh_start  = 0;
        for (int i = 0; i < 16; i++)
        begin
            sh_marks[i]   = '0;
            sh_dbytes[i]  = '0;
            sh_absents[i] = '0;
        end
        sh_total = 0;
    endfunction

    // Stored difference word at a word boundary, zero past the line end
    function automatic logic [63:0] line_word(input int unsigned first);
        logic [63:0] s;
        int unsigned ws;
        ws = word_bytes();
        s  = '0;
        for (int unsigned j = 0; j < ws; j++)
        begin
            s = s << 8;
            if (first + j < 16) s[7:0] = sh_dbytes[first + j];
        end
        return s;
    endfunction

    // Pad and close the pending word; mark its bytes when it differs
    function automatic logic [63:0] close_word(input int unsigned ws);
        logic [63:0] d;
        int unsigned idx;
        for (int unsigned k = sh_fill; k < ws; k++)
        begin
            sh_ref_word = sh_ref_word << 8;
            sh_cmp_word = sh_cmp_word << 8;
        end
        d = sh_cmp_word - sh_ref_word;
        if (sh_word_differs)
        begin
            sh_total = (sh_total + ws > 16'hffff) ? 16'hffff : sh_total + ws;
            for (int unsigned k = 0; k < sh_fill; k++)
            begin
                idx = sh_start + k;
                if (idx < 16)
                begin
                    if (sh_marks[idx] == 0) sh_dbytes[idx] = 8'(d >> (8 * (ws - 1 - k)));
                    sh_marks[idx] = sh_marks[idx] + 8'd1;
                end
            end
        end
        return d;
    endfunction

    // Unmark every word of the line whose stored difference equals the value
    function automatic void unmark_matches(input logic [63:0] value);
        int unsigned ws;
        int unsigned m;
        ws = word_bytes();
        for (int unsigned i = 0; i < 16; i += ws)
        begin
            if (line_word(i) == value)
            begin
                for (int unsigned j = 0; j < ws && i + j < 16; j++)
                begin
                    m = 32'(sh_marks[i + j]);
                    if (m > 0)
                    begin
                        sh_total = (sh_total > m) ? sh_total - m : 0;
                        sh_marks[i + j]   = '0;
                        sh_dbytes[i + j]  = '0;
                        sh_absents[i + j] = '0;
                    end
                end
            end
        end
    endfunction

    // Advance the shadow by one accepted item; return 1 when it yields a result
    function automatic bit step_marker(input item_t it, output outcome_t o);
        int unsigned ws;
        int unsigned off;
        bit          tally_absent;
        ws = word_bytes();
        o  = '{default: '0};
        case (it.kind)
            KIND_CLEAR:
            begin
                clear_line();
                return 0;
            end
            KIND_IGNORE:
            begin
                unmark_matches(it.ign);
                o.tot = 16'(sh_total);
                return 1;
            end
            KIND_READ:
            begin
                o.tot    = 16'(sh_total);
                o.mark   = sh_marks[it.idx];
                o.dbyte  = sh_dbytes[it.idx];
                o.absent = sh_absents[it.idx];
                return 1;
            end
            default:
            begin
                off          = sh_offset;
                tally_absent = 0;
                if (sh_fill == 0) sh_start = off;
                sh_ref_word = sh_ref_word << 8;
                sh_cmp_word = sh_cmp_word << 8;
                if (it.ref_p && it.cmp_p)
                begin
                    sh_ref_word[7:0] = it.ref_b;
                    sh_cmp_word[7:0] = it.cmp_b;
                    if (sh_ref_word != sh_cmp_word) sh_word_differs = 1;
                end
                else if (!it.ref_p && !it.cmp_p)
                    tally_absent = 1;
                else if (sh_absent_diff)
                begin
                    if (it.ref_p) sh_ref_word[7:0] = it.ref_b;
                    else          sh_cmp_word[7:0] = it.cmp_b;
                    sh_word_differs = 1;
                end
                else
                    tally_absent = 1;
                if (tally_absent && off < 16) sh_absents[off] = sh_absents[off] + 8'd1;
                sh_fill++;
                if (sh_offset < 16) sh_offset++;
                if (sh_fill >= ws || it.last)
                begin
                    o.dw  = close_word(ws);
                    o.wd  = sh_word_differs;
                    o.tot = 16'(sh_total);
                    drop_word();
                    if (it.last)
                    begin
                        sh_offset = 0;
                        sh_start  = 0;
                    end
                    return 1;
                end
                return 0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, checking and watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s got %0h, want %0h", $realtime, what, got, want);
    endtask

    // Compare each accepted result with the oldest expected one, field by field
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                note_mismatch("result with nothing pending, difference_word",
                              difference_word, '0);
            else
            begin
                w = pending_results.pop_front();
                if (word_different !== w.wd)
                    note_mismatch("word_different", 64'(word_different), 64'(w.wd));
                if (difference_word !== w.dw)
                    note_mismatch("difference_word", difference_word, w.dw);
                if (total_count !== w.tot)
                    note_mismatch("total_count", 64'(total_count), 64'(w.tot));
                if (mark_count !== w.mark)
                    note_mismatch("mark_count", 64'(mark_count), 64'(w.mark));
                if (diff_byte !== w.dbyte)
                    note_mismatch("diff_byte", 64'(diff_byte), 64'(w.dbyte));
                if (absent_count !== w.absent)
                    note_mismatch("absent_count", 64'(absent_count), 64'(w.absent));
            end
        end
    end

    // Reset the quiet count whenever either side moves an item
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result back-pressure: stall bursts, mostly short, some long, and quiet stretches
    initial
    begin
        int r;
        result_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (sink_steady || r < 50)
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else if (r < 90)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; every task starts and ends on a rising edge
    // ------------------------------------------------------------------
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t make_item(input kind_t k, input logic [7:0] rb, input logic rp,
                                        input logic [7:0] cb, input logic cp, input logic e,
                                        input logic [63:0] ign, input logic [3:0] idx);
        item_t it;
        it.kind  = k;
        it.ref_b = rb;
        it.ref_p = rp;
        it.cmp_b = cb;
        it.cmp_p = cp;
        it.last  = e;
        it.ign   = ign;
        it.idx   = idx;
        return it;
    endfunction

    // Fully random item, used as noise and as a base for shaped items
    function automatic item_t noise_item();
        return make_item(kind_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                         8'($urandom), 1'($urandom), 1'($urandom),
                         {$urandom, $urandom}, 4'($urandom));
    endfunction

    // Drive one item, hold it until accepted, then advance the shadow
    task automatic send_item(input item_t it, input bit typed, input outcome_t want);
        int       gap;
        outcome_t o;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= it.kind;
        ref_byte     <= it.ref_b;
        ref_present  <= it.ref_p;
        cmp_byte     <= it.cmp_b;
        cmp_present  <= it.cmp_p;
        range_end    <= it.last;
        ignore_value <= it.ign;
        entry_index  <= it.idx;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        items_sent++;
        if (step_marker(it, o))
            pending_results.push_back(typed ? want : o);
    endtask

    // Drain the block before a register write
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [3:0] val);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        reg_writes++;
        if (sel == CFG_WSIZE)
        begin
            sh_ws_raw = val;
            drop_word();
        end
        else
            sh_absent_diff = val[0];
        @(posedge clk);
    endtask

    // Random compare run over one range: mostly realistic byte pairs, ending
    // with range_end most of the time
    task automatic compare_run();
        int       len;
        int       r;
        item_t    it;
        outcome_t none;
        none = '{default: '0};
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 26)
                                           : $urandom_range(1, 3 * word_bytes());
        for (int n = 0; n < len; n++)
        begin
            it      = noise_item();
            it.kind = KIND_CMP;
            r       = $urandom_range(0, 99);
            if (r < 50)
            begin
                it.cmp_b = it.ref_b;
                it.ref_p = 1'b1;
                it.cmp_p = 1'b1;
            end
            else if (r < 70)
            begin
                it.ref_p = 1'b1;
                it.cmp_p = 1'b1;
            end
            else if (r < 85)
            begin
                it.ref_p = 1'($urandom);
                it.cmp_p = !it.ref_p;
            end
            else
            begin
                it.ref_p = 1'b0;
                it.cmp_p = 1'b0;
            end
            if (n == len - 1)
                it.last = ($urandom_range(0, 99) < 85);
            else
                it.last = ($urandom_range(0, 99) < 4);
            send_item(it, 0, none);
        end
    endtask

    // New register setting between phases, extremes now and then
    task automatic reconfigure();
        int r;
        settle();
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        if (r < 7)
            write_reg(CFG_WSIZE, 4'($urandom_range(1, 8)));
        else if (r < 8)
            write_reg(CFG_WSIZE, 4'd0);
        else
            write_reg(CFG_WSIZE, 4'($urandom_range(9, 15)));
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_ABSENT, 4'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Directed plan
    // ------------------------------------------------------------------
    plan_row_t plan[$];

    function automatic void add_row(input item_t it, input bit typed, input outcome_t want);
        plan_row_t row;
        row.is_cfg  = 0;
        row.cfg_sel = '0;
        row.cfg_val = '0;
        row.it      = it;
        row.typed   = typed;
        row.want    = want;
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input logic sel, input logic [3:0] val);
        plan_row_t row;
        row.is_cfg  = 1;
        row.cfg_sel = sel;
        row.cfg_val = val;
        row.it      = make_item(KIND_READ, '0, '0, '0, '0, '0, '0, '0);
        row.typed   = 0;
        row.want    = '{default: '0};
        plan.push_back(row);
    endfunction

    function automatic outcome_t out_of(input logic wd, input logic [63:0] dw,
                                        input logic [15:0] tot, input logic [7:0] m,
                                        input logic [7:0] d, input logic [7:0] a);
        outcome_t o;
        o.wd     = wd;
        o.dw     = dw;
        o.tot    = tot;
        o.mark   = m;
        o.dbyte  = d;
        o.absent = a;
        return o;
    endfunction

    function automatic void build_plan();
        outcome_t none;
        none = '{default: '0};
        // Fresh after reset: word size 1, absent bytes only counted
        add_row(make_item(KIND_READ, 8'h00, 0, 8'h00, 0, 0, '0, 4'd0), 1,
                out_of(0, '0, 16'd0, 8'd0, 8'd0, 8'd0));
        add_row(make_item(KIND_CMP, 8'h00, 1, 8'hff, 1, 0, '0, 4'd0), 1,
                out_of(1, 64'hff, 16'd1, 8'd0, 8'd0, 8'd0));
        // Negative difference wraps modulo 2^64
        add_row(make_item(KIND_CMP, 8'hff, 1, 8'h00, 1, 0, '0, 4'd0), 1,
                out_of(1, 64'hffff_ffff_ffff_ff01, 16'd2, 8'd0, 8'd0, 8'd0));
        add_row(make_item(KIND_CMP, 8'h5a, 1, 8'h5a, 1, 0, '0, 4'd0), 1,
                out_of(0, '0, 16'd2, 8'd0, 8'd0, 8'd0));
        add_row(make_item(KIND_CMP, 8'h00, 0, 8'h00, 0, 0, '0, 4'd0), 1,
                out_of(0, '0, 16'd2, 8'd0, 8'd0, 8'd0));
        add_row(make_item(KIND_READ, 8'h00, 0, 8'h00, 0, 0, '0, 4'd0), 1,
                out_of(0, '0, 16'd2, 8'd1, 8'hff, 8'd0));
        add_row(make_item(KIND_READ, 8'h00, 0, 8'h00, 0, 0, '0, 4'd3), 1,
                out_of(0, '0, 16'd2, 8'd0, 8'd0, 8'd1));
        add_row(make_item(KIND_IGNORE, 8'h00, 0, 8'h00, 0, 0, 64'hff, 4'd0), 1,
                out_of(0, '0, 16'd1, 8'd0, 8'd0, 8'd0));
        // One-sided byte with absent mode off closes the range
        add_row(make_item(KIND_CMP, 8'h33, 1, 8'hcc, 0, 1, '0, 4'd0), 0, none);
        add_row(make_item(KIND_CLEAR, 8'hff, 1, 8'hff, 1, 1, '1, 4'd15), 0, none);
        add_row(make_item(KIND_READ, 8'h00, 0, 8'h00, 0, 0, '0, 4'd1), 1,
                out_of(0, '0, 16'd0, 8'd0, 8'd0, 8'd0));
        // Widest word, absent bytes now differences; partial word padded on close
        add_cfg(CFG_WSIZE, 4'd8);
        add_cfg(CFG_ABSENT, 4'd1);
        add_row(make_item(KIND_CMP, 8'h11, 1, 8'h22, 1, 0, '0, 4'd0), 0, none);
        add_row(make_item(KIND_CMP, 8'h00, 0, 8'h80, 1, 0, '0, 4'd0), 0, none);
        add_row(make_item(KIND_CMP, 8'hff, 1, 8'hff, 1, 1, '0, 4'd0), 0, none);
        add_row(make_item(KIND_READ, 8'h00, 0, 8'h00, 0, 0, '0, 4'd1), 0, none);
        // Zero and oversize word sizes are clamped
        add_cfg(CFG_WSIZE, 4'd0);
        add_row(make_item(KIND_CMP, 8'h01, 1, 8'h02, 1, 0, '0, 4'd0), 0, none);
        add_cfg(CFG_WSIZE, 4'd15);
        add_row(make_item(KIND_CMP, 8'hff, 1, 8'h00, 0, 1, '0, 4'd15), 0, none);
        // Word that runs past the line end during an ignore walk
        add_cfg(CFG_WSIZE, 4'd5);
        add_row(make_item(KIND_IGNORE, 8'h00, 0, 8'h00, 0, 0, 64'h0, 4'd0), 0, none);
        add_row(make_item(KIND_IGNORE, 8'h00, 0, 8'h00, 0, 0, '1, 4'd0), 0, none);
        add_row(make_item(KIND_READ, 8'h00, 0, 8'h00, 0, 0, '0, 4'd15), 0, none);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_t    it;
        outcome_t none;
        int       r;
        int       rand_items;
        int       next_cfg;

        none         = '{default: '0};
        mismatches   = 0;
        items_sent   = 0;
        soak_sent    = 0;
        results_seen = 0;
        reg_writes   = 0;
        quiet_cycles = 0;
        src_steady   = 0;
        sink_steady  = 0;

        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= 1'b0;
        cfg_data     <= '0;
        item_valid   <= 1'b0;
        kind         <= KIND_CLEAR;
        ref_byte     <= '0;
        ref_present  <= 1'b0;
        cmp_byte     <= '0;
        cmp_present  <= 1'b0;
        range_end    <= 1'b0;
        ignore_value <= '0;
        entry_index  <= '0;

        sh_ws_raw      = 4'd1;
        sh_absent_diff = 1'b0;
        clear_line();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan
        build_plan();
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].cfg_sel, plan[i].cfg_val);
            end
            else
                send_item(plan[i].it, plan[i].typed, plan[i].want);
        end

        // Soak: single-byte ranges at word size 8 mark the first byte again and
        // again, so its mark count wraps past 255
        settle();
        src_steady = 1;
        write_reg(CFG_WSIZE, 4'd8);
        write_reg(CFG_ABSENT, 4'($urandom));
        send_item(make_item(KIND_CLEAR, '0, 0, '0, 0, 0, '0, '0), 0, none);
        for (int n = 0; n < SOAK_ITEMS; n++)
        begin
            it      = noise_item();
            it.kind = KIND_CMP;
            it.last = 1'b1;
            if (n % 32 == 0)
            begin
                it.ref_p = 1'b0;
                it.cmp_p = 1'b0;
            end
            else
            begin
                it.ref_p = 1'b1;
                it.cmp_p = 1'b1;
                it.cmp_b = it.ref_b ^ 8'($urandom_range(1, 255));
            end
            send_item(it, 0, none);
            soak_sent++;
        end
        src_steady = 0;
        send_item(make_item(KIND_READ, '0, 0, '0, 0, 0, '0, 4'd0), 0, none);
        send_item(make_item(KIND_IGNORE, '0, 0, '0, 0, 0, line_word(0), '0), 0, none);
        send_item(make_item(KIND_READ, '0, 0, '0, 0, 0, '0, 4'd0), 0, none);

        // Random part: shaped compare runs mixed with reads, ignores, clears and noise
        reconfigure();
        send_item(make_item(KIND_CLEAR, '0, 0, '0, 0, 0, '0, '0), 0, none);
        rand_items = items_sent;
        next_cfg   = items_sent + $urandom_range(40, 80);
        while (items_sent - rand_items < RANDOM_ITEMS)
        begin
            if (items_sent >= next_cfg)
            begin
                reconfigure();
                next_cfg = items_sent + $urandom_range(40, 80);
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                compare_run();
            else if (r < 70)
            begin
                it      = noise_item();
                it.kind = KIND_READ;
                send_item(it, 0, none);
            end
            else if (r < 85)
            begin
                it      = noise_item();
                it.kind = KIND_IGNORE;
                r       = $urandom_range(0, 9);
                // Mostly aim at a word actually stored in the line
                if (r < 6)
                    it.ign = line_word(word_bytes() * $urandom_range(0, 15 / word_bytes()));
                else if (r < 8)
                    it.ign = '0;
                send_item(it, 0, none);
            end
            else if (r < 90)
            begin
                it      = noise_item();
                it.kind = KIND_CLEAR;
                send_item(it, 0, none);
            end
            else
                send_item(noise_item(), 0, none);
        end

        // Drain and let the block go quiet
        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_mismatch("results left pending", 64'(pending_results.size()), '0);

        $display("ran %0d items (%0d in the first-byte soak) and checked %0d results",
                 items_sent, soak_sent, results_seen);
        $display("made %0d register writes across word sizes 0..15 and both absent modes",
                 reg_writes);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
